>>> rtl/i2c_eeprom_read_sequencer_unit_defines.svh
// ----------------------------------------------------------------------------
// I2C EEPROM read sequencer: assertion macros
// Shared assertion forms for the checker; clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_READ_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_EEPROM_READ_SEQUENCER_UNIT_DEFINES_SVH

// implication property, checked at every edge outside reset
`define I2CERS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define I2CERS_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> rtl/i2cers_pkg.sv
// ----------------------------------------------------------------------------
// I2C EEPROM read sequencer package
// Action, phase, result and command codes, command and beat records.
// ----------------------------------------------------------------------------
package i2cers_pkg;

	localparam logic [2:0] ACT_START_SEND = 3'd0;
	localparam logic [2:0] ACT_SEND       = 3'd1;
	localparam logic [2:0] ACT_READ       = 3'd2;
	localparam logic [2:0] ACT_READ_LAST  = 3'd3;
	localparam logic [2:0] ACT_STOP       = 3'd4;
	localparam logic [2:0] ACT_DATA       = 3'd5;
	localparam logic [2:0] ACT_FINISH     = 3'd6;

	localparam logic [2:0] RC_OK       = 3'd0;
	localparam logic [2:0] RC_NO_DEV   = 3'd1;
	localparam logic [2:0] RC_NO_WORD  = 3'd2;
	localparam logic [2:0] RC_NO_READ  = 3'd3;
	localparam logic [2:0] RC_BUS_ERR  = 3'd4;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_DEV   = 3'd1;
	localparam logic [2:0] PH_WORD  = 3'd2;
	localparam logic [2:0] PH_RADDR = 3'd3;
	localparam logic [2:0] PH_READ  = 3'd4;

	localparam logic       REQ_BEGIN = 1'b0;

	localparam logic [1:0] CFG_READ_LENGTH = 2'd0;
	localparam logic [1:0] CFG_WORD_ADDR   = 2'd1;
	localparam logic [1:0] CFG_POLL_LIMIT  = 2'd2;

	localparam logic [8:0]  READ_LENGTH_RST = 9'd256;
	localparam logic [8:0]  READ_LENGTH_MAX = 9'd256;
	localparam logic [15:0] POLL_LIMIT_RST  = 16'd30000;
	localparam logic [15:0] POLL_CNT_SAT    = 16'hFFFF;

	typedef enum logic [1:0] {
		CMD_SINGLE    = 2'd0,
		CMD_FAIL      = 2'd1,
		CMD_DATA_READ = 2'd2,
		CMD_DATA_DONE = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [2:0] act;
		logic [7:0] data;
		logic [7:0] idx;
		logic [2:0] code;
	} cmd_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] out_byte;
		logic [7:0] byte_index;
		logic [2:0] result_code;
		logic       last;
	} beat_t;

endpackage

>>> rtl/i2cers_cmdq.sv
// ----------------------------------------------------------------------------
// I2C EEPROM read sequencer: command queue
// Small FIFO of commands between the front and back parts.
// ----------------------------------------------------------------------------
module i2cers_cmdq #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  i2cers_pkg::cmd_t wr_cmd,
	output logic             full,
	input  logic             rd_en,
	output i2cers_pkg::cmd_t rd_cmd,
	output logic             avail
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	i2cers_pkg::cmd_t  mem_q [DEPTH];
	logic [PTR_W-1:0]  wptr_q;
	logic [PTR_W-1:0]  rptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign full   = (cnt_q == CNT_W'(DEPTH));
	assign avail  = (cnt_q != '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && avail;
	assign rd_cmd = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/i2cers_front.sv
// ----------------------------------------------------------------------------
// I2C EEPROM read sequencer: front part
// Holds configuration and transfer phase, classifies each request or poll,
// and turns a begin or a completing poll into one command for the back part.
// ----------------------------------------------------------------------------
module i2cers_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             req_type,
	input  logic [6:0]       device_address,
	input  logic             done_flag,
	input  logic             ack_flag,
	input  logic             bus_error_flag,
	input  logic [7:0]       received_byte,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	output logic             cmd_push,
	output i2cers_pkg::cmd_t cmd
);

	logic [8:0]  read_length_q;
	logic [7:0]  word_addr_q;
	logic [15:0] poll_limit_q;

	logic [2:0]  phase_q;
	logic [8:0]  read_pos_q;
	logic [15:0] poll_cnt_q;
	logic [6:0]  held_addr_q;

	logic [2:0]  phase_d;
	logic [8:0]  read_pos_d;
	logic [15:0] poll_cnt_d;
	logic [6:0]  held_addr_d;
	logic        gen;

	logic [15:0] limit;
	logic [8:0]  eff_len;
	logic [15:0] pc_inc;
	logic        complete;
	logic [8:0]  pos_inc;
	logic [9:0]  pos_inc2;

	assign limit    = (poll_limit_q == '0) ? 16'd1 : poll_limit_q;
	assign eff_len  = (read_length_q == '0) ? 9'd1 :
		(read_length_q > i2cers_pkg::READ_LENGTH_MAX) ? i2cers_pkg::READ_LENGTH_MAX :
		read_length_q;
	assign pc_inc   = (poll_cnt_q != i2cers_pkg::POLL_CNT_SAT) ? poll_cnt_q + 16'd1 : poll_cnt_q;
	assign complete = done_flag || bus_error_flag || (pc_inc >= limit);
	assign pos_inc  = read_pos_q + 9'd1;
	assign pos_inc2 = {1'b0, pos_inc} + 10'd1;

	always_comb begin
		phase_d     = phase_q;
		read_pos_d  = read_pos_q;
		poll_cnt_d  = poll_cnt_q;
		held_addr_d = held_addr_q;
		gen         = 1'b0;
		cmd         = '0;
		cmd.kind    = i2cers_pkg::CMD_SINGLE;
		if (req_type == i2cers_pkg::REQ_BEGIN) begin
			held_addr_d = device_address;
			poll_cnt_d  = '0;
			read_pos_d  = '0;
			phase_d     = i2cers_pkg::PH_DEV;
			gen         = 1'b1;
			cmd.act     = i2cers_pkg::ACT_START_SEND;
			cmd.data    = {device_address, 1'b0};
		end else if (phase_q != i2cers_pkg::PH_IDLE) begin
			poll_cnt_d = pc_inc;
			if (complete) begin
				poll_cnt_d = '0;
				gen        = 1'b1;
				if (phase_q == i2cers_pkg::PH_READ) begin
					if (bus_error_flag) begin
						cmd.kind = i2cers_pkg::CMD_FAIL;
						cmd.code = i2cers_pkg::RC_BUS_ERR;
						phase_d  = i2cers_pkg::PH_IDLE;
					end else begin
						read_pos_d = pos_inc;
						cmd.data   = received_byte;
						cmd.idx    = read_pos_q[7:0];
						if (pos_inc >= eff_len) begin
							cmd.kind = i2cers_pkg::CMD_DATA_DONE;
							phase_d  = i2cers_pkg::PH_IDLE;
						end else begin
							cmd.kind = i2cers_pkg::CMD_DATA_READ;
							cmd.act  = (pos_inc2 >= {1'b0, eff_len}) ?
								i2cers_pkg::ACT_READ_LAST : i2cers_pkg::ACT_READ;
						end
					end
				end else if (!ack_flag || bus_error_flag) begin
					cmd.kind = i2cers_pkg::CMD_FAIL;
					phase_d  = i2cers_pkg::PH_IDLE;
					unique case (phase_q)
						i2cers_pkg::PH_DEV:  cmd.code = i2cers_pkg::RC_NO_DEV;
						i2cers_pkg::PH_WORD: cmd.code = i2cers_pkg::RC_NO_WORD;
						default:             cmd.code = i2cers_pkg::RC_NO_READ;
					endcase
				end else begin
					unique case (phase_q)
						i2cers_pkg::PH_DEV: begin
							cmd.act  = i2cers_pkg::ACT_SEND;
							cmd.data = word_addr_q;
							phase_d  = i2cers_pkg::PH_WORD;
						end
						i2cers_pkg::PH_WORD: begin
							cmd.act  = i2cers_pkg::ACT_START_SEND;
							cmd.data = {held_addr_q, 1'b1};
							phase_d  = i2cers_pkg::PH_RADDR;
						end
						default: begin
							read_pos_d = '0;
							cmd.act    = (eff_len == 9'd1) ?
								i2cers_pkg::ACT_READ_LAST : i2cers_pkg::ACT_READ;
							phase_d    = i2cers_pkg::PH_READ;
						end
					endcase
				end
			end
		end
	end

	assign cmd_push = accept && gen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_length_q <= i2cers_pkg::READ_LENGTH_RST;
			word_addr_q   <= '0;
			poll_limit_q  <= i2cers_pkg::POLL_LIMIT_RST;
			phase_q       <= i2cers_pkg::PH_IDLE;
			read_pos_q    <= '0;
			poll_cnt_q    <= '0;
			held_addr_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					i2cers_pkg::CFG_READ_LENGTH: read_length_q <= cfg_data[8:0];
					i2cers_pkg::CFG_WORD_ADDR:   word_addr_q   <= cfg_data[7:0];
					i2cers_pkg::CFG_POLL_LIMIT:  poll_limit_q  <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				phase_q     <= phase_d;
				read_pos_q  <= read_pos_d;
				poll_cnt_q  <= poll_cnt_d;
				held_addr_q <= held_addr_d;
			end
		end
	end

endmodule

>>> rtl/i2cers_back.sv
// ----------------------------------------------------------------------------
// I2C EEPROM read sequencer: back part
// Expands each command into one to three result beats and holds the
// oldest beat in an output register.
// ----------------------------------------------------------------------------
module i2cers_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_avail,
	input  i2cers_pkg::cmd_t  cmd,
	output logic              cmd_pop,
	input  logic              out_pop,
	output logic              out_valid,
	output i2cers_pkg::beat_t out_beat
);

	logic [1:0]        step_q;
	logic              out_valid_q;
	i2cers_pkg::beat_t out_q;
	i2cers_pkg::beat_t beat;
	logic              out_free;
	logic              emit;

	always_comb begin
		beat        = '0;
		beat.action = i2cers_pkg::ACT_STOP;
		unique case (cmd.kind)
			i2cers_pkg::CMD_SINGLE: begin
				beat.action   = cmd.act;
				beat.out_byte = cmd.data;
				beat.last     = 1'b1;
			end
			i2cers_pkg::CMD_FAIL: begin
				if (step_q != 2'd0) begin
					beat.action      = i2cers_pkg::ACT_FINISH;
					beat.result_code = cmd.code;
					beat.last        = 1'b1;
				end
			end
			i2cers_pkg::CMD_DATA_READ: begin
				if (step_q == 2'd0) begin
					beat.action     = i2cers_pkg::ACT_DATA;
					beat.out_byte   = cmd.data;
					beat.byte_index = cmd.idx;
				end else begin
					beat.action = cmd.act;
					beat.last   = 1'b1;
				end
			end
			default: begin
				if (step_q == 2'd0) begin
					beat.action     = i2cers_pkg::ACT_DATA;
					beat.out_byte   = cmd.data;
					beat.byte_index = cmd.idx;
				end else if (step_q == 2'd2) begin
					beat.action      = i2cers_pkg::ACT_FINISH;
					beat.result_code = i2cers_pkg::RC_OK;
					beat.last        = 1'b1;
				end
			end
		endcase
	end

	assign out_free  = !out_valid_q || out_pop;
	assign emit      = cmd_avail && out_free;
	assign cmd_pop   = emit && beat.last;
	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				step_q <= beat.last ? 2'd0 : step_q + 2'd1;
			end
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

endmodule

>>> rtl/i2c_eeprom_read_sequencer_unit.sv
// ----------------------------------------------------------------------------
// I2C EEPROM read sequencer
// Steps a byte-level I2C master through a 24Cxx random plus sequential read.
// ----------------------------------------------------------------------------
// Input side is a queue write: begin requests and controller status polls
// enter when push is high and full is low. Results leave as a queue read:
// the oldest beat sits on the result ports while empty is low and is taken
// when pop is high. Configuration (read length, word address, poll limit)
// is written over cfg_valid/cfg_ready/cfg_index/cfg_data while idle;
// cfg_ready is always high and unknown indexes are dropped.
// A request is classified in its accept cycle; a begin or a completing poll
// is queued as one command, whose first beat moves from the queue into the
// output register when it is free and can be taken at the next edge.
// The input takes a request every clock while full is low; the back expander
// emits each command as one to three beats, one per clock while not stalled.
// Reset clears the transfer phase, the queue and the output register and
// restores the configuration defaults (256 bytes, word 0, 30000 polls).
// When pop stays low the output register holds, the command queue fills
// (CMD_DEPTH entries) and then full rises until beats drain.
// ----------------------------------------------------------------------------
module i2c_eeprom_read_sequencer_unit #(
	parameter int CMD_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        req_type,
	input  logic [6:0]  device_address,
	input  logic        done_flag,
	input  logic        ack_flag,
	input  logic        bus_error_flag,
	input  logic [7:0]  received_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  action,
	output logic [7:0]  out_byte,
	output logic [7:0]  byte_index,
	output logic [2:0]  result_code,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic              accept;
	logic              cmd_push;
	i2cers_pkg::cmd_t  cmd_in;
	i2cers_pkg::cmd_t  cmd_head;
	logic              cmd_avail;
	logic              cmd_pop;
	logic              out_valid;
	i2cers_pkg::beat_t out_beat;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	i2cers_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.req_type       (req_type),
		.device_address (device_address),
		.done_flag      (done_flag),
		.ack_flag       (ack_flag),
		.bus_error_flag (bus_error_flag),
		.received_byte  (received_byte),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd_push       (cmd_push),
		.cmd            (cmd_in)
	);

	i2cers_cmdq #(
		.DEPTH (CMD_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_cmd (cmd_in),
		.full   (full),
		.rd_en  (cmd_pop),
		.rd_cmd (cmd_head),
		.avail  (cmd_avail)
	);

	i2cers_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (cmd_avail),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.out_pop   (pop),
		.out_valid (out_valid),
		.out_beat  (out_beat)
	);

	assign empty       = !out_valid;
	assign action      = out_beat.action;
	assign out_byte    = out_beat.out_byte;
	assign byte_index  = out_beat.byte_index;
	assign result_code = out_beat.result_code;
	assign last        = out_beat.last;

endmodule

>>> rtl/i2cers_checker.sv
// ----------------------------------------------------------------------------
// I2C EEPROM read sequencer: port checker
// Watches the result port for beat ordering and field rules.
// ----------------------------------------------------------------------------
`include "i2c_eeprom_read_sequencer_unit_defines.svh"

module i2cers_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [2:0] action,
	input logic [7:0] out_byte,
	input logic [2:0] result_code,
	input logic       last
);

	`I2CERS_ASSERT(a_hold_stalled, (!empty && !pop) |=> (!empty && $stable(action) && $stable(out_byte) && $stable(last)), "result beat changed while stalled")
	`I2CERS_ASSERT(a_finish_last, (!empty && action == i2cers_pkg::ACT_FINISH) |-> last, "finish beat not marked last")
	`I2CERS_ASSERT_NEVER(a_stop_last, !empty && last && (action == i2cers_pkg::ACT_STOP || action == i2cers_pkg::ACT_DATA), "stop or data beat marked last")
	`I2CERS_ASSERT_NEVER(a_code_finish, !empty && action != i2cers_pkg::ACT_FINISH && result_code != i2cers_pkg::RC_OK, "result code on a non-finish beat")

endmodule

bind i2c_eeprom_read_sequencer_unit i2cers_checker u_i2cers_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.action      (action),
	.out_byte    (out_byte),
	.result_code (result_code),
	.last        (last)
);
